>>> hdl/gaes_pkg.sv
// Shared types and constants for the graph adjacency edge store.
// Used by gaes_ctrl, gaes_datapath and graph_adjacency_edge_store; depends on nothing.
`default_nettype none

package gaes_pkg;

    localparam int MAX_NODES  = 64;
    localparam int MAX_DEGREE = 16;
    localparam int LOG_DEPTH  = 256;

    localparam int NODE_W = 6;
    localparam int SLOT_W = 4;
    localparam int DEG_W  = 5;
    localparam int LOGC_W = 9;
    localparam int LOG_AW = 8;
    localparam int NBR_AW = NODE_W + SLOT_W;

    typedef enum logic [1:0] {
        KIND_ADD     = 2'd0,
        KIND_DELETE  = 2'd1,
        KIND_RESTORE = 2'd2,
        KIND_READ    = 2'd3
    } gaes_kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_LIST_FULL  = 3'd2,
        ST_LOG_FULL   = 3'd3,
        ST_SLOT_RANGE = 3'd4
    } gaes_status_t;

    typedef struct packed {
        gaes_kind_t          kind;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [SLOT_W-1:0]   slot;
    } gaes_request_t;

    typedef struct packed {
        gaes_status_t        status;
        logic [DEG_W-1:0]    degree_a;
        logic [DEG_W-1:0]    degree_b;
        logic [NODE_W-1:0]   neighbor;
        logic [LOGC_W-1:0]   removed_count;
    } gaes_result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_WAIT,
        S_CAP,
        S_ADD_CHK,
        S_ADD_A,
        S_ADD_B,
        S_SCAN_A,
        S_SCAN_B,
        S_SCAN_C,
        S_NOT_FOUND,
        S_LOG_CHK,
        S_RM_A_RD,
        S_RM_A_WR,
        S_RM_B_RD,
        S_RM_B_WR,
        S_READ_CHK,
        S_READ_DATA,
        S_RS_NEXT,
        S_RS_LOAD,
        S_RS_WAIT,
        S_RS_CAP,
        S_RS_DONE,
        S_FINISH
    } gaes_state_t;

    // Side select: 0 works on node_a's list, 1 on node_b's list.
    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;

    typedef struct packed {
        logic         load_req;
        logic         load_log;
        logic         restore_ab;
        logic         cap_deg;
        logic         log_rd;
        logic         log_wr;
        logic         log_clear;
        logic         scan_init;
        logic         scan_step;
        logic         rm_rd;
        logic         rm_wr;
        logic         add_wr;
        logic         rd_slot;
        logic         nb_load;
        logic         set_status;
        gaes_status_t status;
        logic         sel;
        logic         finish;
    } gaes_cmd_t;

    typedef struct packed {
        gaes_kind_t   kind;
        logic         self_loop;
        logic         add_ok;
        logic         scan_done;
        logic [1:0]   scan_cnt;
        logic         log_full;
        logic         log_more;
        logic         slot_ok;
    } gaes_stat_t;

endpackage

`default_nettype wire

>>> hdl/graph_adjacency_edge_store.sv
// Top level of the graph adjacency edge store: controller plus datapath.
// Depends on gaes_pkg, gaes_ctrl and gaes_datapath.
//
// A request is taken at a rising edge where start is high and busy is low; its single
// result appears on result for exactly one cycle with done high, and the receiver must
// take it then, since nothing holds it. Busy drops in the cycle done is shown, so the
// next request may be issued at once. A delete of a self loop scans its list twice.
// The neighbor memory has a single read port, which the delete scan walks one entry
// per cycle, and restore writes it twice for each replayed edge that still fits. The
// degree table is valid after reset with no clearing pass.
`default_nettype none

module graph_adjacency_edge_store
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire gaes_pkg::gaes_request_t request,
    output logic                         done,
    output gaes_pkg::gaes_result_t       result
);
    import gaes_pkg::*;

    gaes_cmd_t  cmd;
    gaes_stat_t stat;

    gaes_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    gaes_datapath u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire

>>> hdl/gaes_ctrl.sv
// Controller state machine of the graph adjacency edge store.
// Depends on gaes_pkg; drives gaes_datapath through command and status structs.
`default_nettype none

module gaes_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire gaes_pkg::gaes_stat_t stat,
    output gaes_pkg::gaes_cmd_t       cmd
);
    import gaes_pkg::*;

    gaes_state_t state_reg;
    gaes_state_t state_next;
    gaes_state_t add_ret;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy    = (state_reg != S_IDLE);
    // An add during restore returns to the replay loop.
    assign add_ret = (stat.kind == KIND_RESTORE) ? S_RS_NEXT : S_FINISH;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = (stat.kind == KIND_RESTORE) ? S_RS_NEXT : S_CAP;
            end
            S_WAIT:      state_next = S_CAP;
            S_CAP:
            begin
                unique case (stat.kind)
                    KIND_ADD:     state_next = S_ADD_CHK;
                    KIND_DELETE:  state_next = S_SCAN_A;
                    KIND_RESTORE: state_next = S_FINISH;
                    KIND_READ:    state_next = S_READ_CHK;
                    default:      state_next = S_FINISH;
                endcase
            end
            S_ADD_CHK:   state_next = stat.add_ok ? S_ADD_A : add_ret;
            S_ADD_A:     state_next = S_ADD_B;
            S_ADD_B:     state_next = add_ret;
            S_SCAN_A:
            begin
                if (stat.scan_done)
                begin
                    if (stat.self_loop)
                    begin
                        state_next = (stat.scan_cnt >= 2'd2) ? S_LOG_CHK : S_NOT_FOUND;
                    end
                    else
                    begin
                        state_next = (stat.scan_cnt != 2'd0) ? S_SCAN_B : S_NOT_FOUND;
                    end
                end
            end
            S_SCAN_B:
            begin
                if (stat.scan_done)
                begin
                    state_next = (stat.scan_cnt != 2'd0) ? S_LOG_CHK : S_NOT_FOUND;
                end
            end
            S_SCAN_C:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_RM_B_RD;
                end
            end
            S_NOT_FOUND: state_next = S_FINISH;
            S_LOG_CHK:   state_next = stat.log_full ? S_FINISH : S_RM_A_RD;
            S_RM_A_RD:   state_next = S_RM_A_WR;
            S_RM_A_WR:   state_next = stat.self_loop ? S_SCAN_C : S_RM_B_RD;
            S_RM_B_RD:   state_next = S_RM_B_WR;
            S_RM_B_WR:   state_next = S_FINISH;
            S_READ_CHK:  state_next = stat.slot_ok ? S_READ_DATA : S_FINISH;
            S_READ_DATA: state_next = S_FINISH;
            S_RS_NEXT:   state_next = stat.log_more ? S_RS_LOAD : S_RS_DONE;
            S_RS_LOAD:   state_next = S_RS_WAIT;
            S_RS_WAIT:   state_next = S_RS_CAP;
            S_RS_CAP:    state_next = S_ADD_CHK;
            S_RS_DONE:   state_next = S_WAIT;
            S_FINISH:    state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.status = ST_OK;
        unique case (state_reg)
            S_IDLE:      cmd.load_req = start;
            S_DECODE:    ;
            S_WAIT:      ;
            S_CAP:
            begin
                cmd.cap_deg   = 1'b1;
                cmd.scan_init = 1'b1;
            end
            S_ADD_CHK:
            begin
                if (!stat.add_ok)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_LIST_FULL;
                end
            end
            S_ADD_A:
            begin
                cmd.add_wr = 1'b1;
                cmd.sel    = SEL_A;
            end
            S_ADD_B:
            begin
                cmd.add_wr = 1'b1;
                cmd.sel    = SEL_B;
            end
            S_SCAN_A:
            begin
                cmd.scan_step = 1'b1;
                cmd.sel       = SEL_A;
                cmd.scan_init = stat.scan_done;
            end
            S_SCAN_B, S_SCAN_C:
            begin
                cmd.scan_step = 1'b1;
                cmd.sel       = SEL_B;
            end
            S_NOT_FOUND:
            begin
                cmd.set_status = 1'b1;
                cmd.status     = ST_NOT_FOUND;
            end
            S_LOG_CHK:
            begin
                if (stat.log_full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_LOG_FULL;
                end
                else
                begin
                    cmd.log_wr = 1'b1;
                end
            end
            S_RM_A_RD:
            begin
                cmd.rm_rd = 1'b1;
                cmd.sel   = SEL_A;
            end
            S_RM_A_WR:
            begin
                cmd.rm_wr     = 1'b1;
                cmd.sel       = SEL_A;
                cmd.scan_init = 1'b1;
            end
            S_RM_B_RD:
            begin
                cmd.rm_rd = 1'b1;
                cmd.sel   = SEL_B;
            end
            S_RM_B_WR:
            begin
                cmd.rm_wr = 1'b1;
                cmd.sel   = SEL_B;
            end
            S_READ_CHK:
            begin
                if (stat.slot_ok)
                begin
                    cmd.rd_slot = 1'b1;
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_SLOT_RANGE;
                end
            end
            S_READ_DATA: cmd.nb_load = 1'b1;
            S_RS_NEXT:   cmd.log_rd = 1'b1;
            S_RS_LOAD:   cmd.load_log = 1'b1;
            S_RS_WAIT:   ;
            S_RS_CAP:    cmd.cap_deg = 1'b1;
            S_RS_DONE:
            begin
                cmd.log_clear  = 1'b1;
                cmd.restore_ab = 1'b1;
            end
            S_FINISH:    cmd.finish = 1'b1;
            default:     ;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/gaes_datapath.sv
// Datapath of the graph adjacency edge store: degree table, neighbor memory,
// removal log, list scanner and result register. Depends on gaes_pkg.
`default_nettype none

module gaes_datapath
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire gaes_pkg::gaes_request_t request,
    input  wire gaes_pkg::gaes_cmd_t     cmd,
    output gaes_pkg::gaes_stat_t         stat,
    output logic                         done,
    output gaes_pkg::gaes_result_t       result
);
    import gaes_pkg::*;

    // Latched request and the endpoints currently being worked on.
    gaes_kind_t          kind_reg;
    logic [NODE_W-1:0]   req_a_reg;
    logic [NODE_W-1:0]   req_b_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [NODE_W-1:0]   a_reg;
    logic [NODE_W-1:0]   b_reg;

    logic [DEG_W-1:0]    da_reg;
    logic [DEG_W-1:0]    db_reg;
    logic [DEG_W-1:0]    da_next;
    logic [DEG_W-1:0]    db_next;
    logic [DEG_W-1:0]    rd_da_reg;
    logic [DEG_W-1:0]    rd_db_reg;

    gaes_status_t        status_reg;
    logic [NODE_W-1:0]   nb_reg;

    // Storage.
    logic [DEG_W-1:0]    deg_mem [MAX_NODES];
    logic [MAX_NODES-1:0] deg_vld_reg;
    logic [NODE_W-1:0]   nbr_mem [MAX_NODES*MAX_DEGREE];
    logic [2*NODE_W-1:0] log_mem [LOG_DEPTH];
    logic [LOGC_W-1:0]   log_count_reg;
    logic [LOGC_W-1:0]   e_reg;
    logic [2*NODE_W-1:0] log_rd_reg;
    logic [NODE_W-1:0]   nb_rd_reg;

    // Scanner.
    logic [DEG_W-1:0]    scan_k_reg;
    logic                pend_reg;
    logic [SLOT_W-1:0]   pidx_reg;
    logic [1:0]          cnt_reg;
    logic [SLOT_W-1:0]   pa_reg;
    logic [SLOT_W-1:0]   pb_reg;

    logic                done_reg;
    gaes_result_t        result_reg;

    logic [NODE_W-1:0]   own;
    logic [NODE_W-1:0]   other;
    logic [DEG_W-1:0]    od;
    logic [DEG_W-1:0]    od_new;
    logic [SLOT_W-1:0]   pos_sel;
    logic                self_loop;
    logic [NBR_AW-1:0]   nbr_raddr;
    logic [NBR_AW-1:0]   nbr_waddr;
    logic [NODE_W-1:0]   nbr_wdata;
    logic                wr_en;
    logic                hit;

    assign self_loop = (a_reg == b_reg);
    assign own       = (cmd.sel == SEL_B) ? b_reg : a_reg;
    assign other     = (cmd.sel == SEL_B) ? a_reg : b_reg;
    assign od        = (cmd.sel == SEL_B) ? db_reg : da_reg;
    assign pos_sel   = (cmd.sel == SEL_B) ? pb_reg : pa_reg;
    assign od_new    = cmd.add_wr ? (od + DEG_W'(1)) : (od - DEG_W'(1));
    assign wr_en     = cmd.add_wr | cmd.rm_wr;
    assign hit       = pend_reg && (nb_rd_reg == other);

    always_comb
    begin
        if (cmd.rm_rd)
        begin
            nbr_raddr = {own, od_new[SLOT_W-1:0]};
        end
        else if (cmd.rd_slot)
        begin
            nbr_raddr = {a_reg, slot_reg};
        end
        else
        begin
            nbr_raddr = {own, scan_k_reg[SLOT_W-1:0]};
        end
    end

    // An add appends at the current degree; a removal fills the hole with the last entry.
    assign nbr_waddr = cmd.add_wr ? {own, od[SLOT_W-1:0]} : {own, pos_sel};
    assign nbr_wdata = cmd.add_wr ? other : nb_rd_reg;

    always_comb
    begin
        da_next = da_reg;
        db_next = db_reg;
        if (cmd.cap_deg)
        begin
            da_next = rd_da_reg;
            db_next = rd_db_reg;
        end
        else if (wr_en)
        begin
            // A self loop keeps both copies of the same degree in step.
            if (cmd.sel == SEL_B || self_loop)
            begin
                db_next = od_new;
            end
            if (cmd.sel == SEL_A || self_loop)
            begin
                da_next = od_new;
            end
        end
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            deg_mem[own]       <= od_new;
            nbr_mem[nbr_waddr] <= nbr_wdata;
        end
        if (cmd.log_wr)
        begin
            log_mem[log_count_reg[LOG_AW-1:0]] <= {a_reg, b_reg};
        end
        rd_da_reg  <= deg_vld_reg[a_reg] ? deg_mem[a_reg] : '0;
        rd_db_reg  <= deg_vld_reg[b_reg] ? deg_mem[b_reg] : '0;
        nb_rd_reg  <= nbr_mem[nbr_raddr];
        if (cmd.log_rd)
        begin
            log_rd_reg <= log_mem[e_reg[LOG_AW-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        da_reg <= da_next;
        db_reg <= db_next;
        if (cmd.load_req)
        begin
            kind_reg   <= request.kind;
            req_a_reg  <= request.node_a;
            req_b_reg  <= request.node_b;
            slot_reg   <= request.slot;
            a_reg      <= request.node_a;
            b_reg      <= request.node_b;
            status_reg <= ST_OK;
            nb_reg     <= '0;
            e_reg      <= '0;
        end
        else
        begin
            if (cmd.load_log)
            begin
                a_reg <= log_rd_reg[2*NODE_W-1:NODE_W];
                b_reg <= log_rd_reg[NODE_W-1:0];
                e_reg <= e_reg + LOGC_W'(1);
            end
            else if (cmd.restore_ab)
            begin
                a_reg <= req_a_reg;
                b_reg <= req_b_reg;
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
            if (cmd.nb_load)
            begin
                nb_reg <= nb_rd_reg;
            end
        end

        // The scan issues one read a cycle and compares the entry read the cycle before.
        if (cmd.scan_init)
        begin
            scan_k_reg <= '0;
            pend_reg   <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else if (cmd.scan_step)
        begin
            if (scan_k_reg < od)
            begin
                pend_reg   <= 1'b1;
                pidx_reg   <= scan_k_reg[SLOT_W-1:0];
                scan_k_reg <= scan_k_reg + DEG_W'(1);
            end
            else
            begin
                pend_reg <= 1'b0;
            end
            if (hit)
            begin
                if (cnt_reg != 2'd2)
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                end
                if (cnt_reg == 2'd0)
                begin
                    if (cmd.sel == SEL_B)
                    begin
                        pb_reg <= pidx_reg;
                    end
                    else
                    begin
                        pa_reg <= pidx_reg;
                    end
                end
            end
        end

        if (cmd.finish)
        begin
            result_reg.status        <= status_reg;
            result_reg.degree_a      <= da_reg;
            result_reg.degree_b      <= db_reg;
            result_reg.neighbor      <= nb_reg;
            result_reg.removed_count <= log_count_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_vld_reg   <= '0;
            log_count_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                deg_vld_reg[own] <= 1'b1;
            end
            if (cmd.log_clear)
            begin
                log_count_reg <= '0;
            end
            else if (cmd.log_wr)
            begin
                log_count_reg <= log_count_reg + LOGC_W'(1);
            end
            done_reg <= cmd.finish;
        end
    end

    always_comb
    begin
        stat.kind      = kind_reg;
        stat.self_loop = self_loop;
        if (self_loop)
        begin
            stat.add_ok = ({1'b0, da_reg} + (DEG_W+1)'(2)) <= (DEG_W+1)'(MAX_DEGREE);
        end
        else
        begin
            stat.add_ok = (da_reg < DEG_W'(MAX_DEGREE)) && (db_reg < DEG_W'(MAX_DEGREE));
        end
        stat.scan_done = (scan_k_reg >= od) && !pend_reg;
        stat.scan_cnt  = cnt_reg;
        stat.log_full  = (log_count_reg >= LOGC_W'(LOG_DEPTH));
        stat.log_more  = (e_reg < log_count_reg);
        stat.slot_ok   = (DEG_W'(slot_reg) < da_reg) &&
                         (DEG_W'(slot_reg) < DEG_W'(MAX_DEGREE));
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
